// File: hdl/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

   localparam int SEQ_W = 32;
   localparam int WIN_W = 6;
   localparam int TIMEOUT_W = 16;
   localparam int MODE_W = 2;
   localparam int KIND_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W = 1;

   localparam int STORE_DEPTH_DEF = 64;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SENT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESENT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ACKED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 1'd1;

   localparam logic [WIN_W-1:0] RESET_WINDOW = 6'd4;
   localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = 16'd500;

   typedef struct packed {
      logic send_ok;
      logic send_refuse;
      logic ack_take;
      logic tick_count;
      logic tick_fire;
      logic resend_emit;
   } cmd_type;

   typedef struct packed {
      logic room;
      logic ack_ok;
      logic due;
      logic busy;
      logic resend_last;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/gbn_ram.sv
`default_nettype none

module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/gbn_datapath.sv
`default_nettype none

module gbn_datapath import gbn_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [SEQ_W-1:0]        req_ack_seq,
   input  wire logic [PAYLOAD_BITS-1:0] req_payload,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   output logic      [KIND_W-1:0]       rsp_kind,
   output logic      [SEQ_W-1:0]        rsp_seq_out,
   output logic      [PAYLOAD_BITS-1:0] rsp_payload_out,
   output logic                         rsp_last
);

   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SUM_W = ((IDX_W > WIN_W) ? IDX_W : WIN_W) + 1;
   localparam int DATA_KEEP = (PAYLOAD_BITS < SEQ_W) ? PAYLOAD_BITS : SEQ_W;
   localparam logic [PAYLOAD_BITS-1:0] KEEP_MASK =
      PAYLOAD_BITS'((65'(1) << DATA_KEEP) - 65'(1));
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(STORE_DEPTH);

   logic [WIN_W-1:0]        window_ff, window_in;
   logic [TIMEOUT_W-1:0]    timeout_ff, timeout_in;
   logic [SEQ_W-1:0]        base_ff, base_in;
   logic [SEQ_W-1:0]        next_ff, next_in;
   logic [WIN_W-1:0]        cnt_ff, cnt_in;
   logic [TIMEOUT_W-1:0]    timer_ff, timer_in;
   logic [IDX_W-1:0]        head_idx_ff, head_idx_in;
   logic [IDX_W-1:0]        base_idx_ff, base_idx_in;
   logic [IDX_W-1:0]        rs_idx_ff, rs_idx_in;
   logic [WIN_W-1:0]        rs_cnt_ff, rs_cnt_in;
   logic [SEQ_W-1:0]        rs_seq_ff, rs_seq_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic [PAYLOAD_BITS-1:0] data_ff, data_in;
   logic                    last_ff, last_in;

   logic [SEQ_W-1:0]        ack_diff;
   logic [SEQ_W-1:0]        ack_base;
   logic [WIN_W-1:0]        ack_cnt;
   logic [SUM_W-1:0]        idx_gap;
   logic [SUM_W-1:0]        idx_wrap;
   logic [PAYLOAD_BITS-1:0] req_data;
   logic [IDX_W-1:0]        head_next;
   logic [IDX_W-1:0]        rs_idx_next;
   logic                    ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [PAYLOAD_BITS-1:0] ram_rd_data;

   assign req_data = req_payload & KEEP_MASK;
   assign ack_diff = req_ack_seq - base_ff;
   assign ack_base = req_ack_seq + SEQ_W'(1);
   assign ack_cnt = cnt_ff - ack_diff[WIN_W-1:0] - WIN_W'(1);
   assign idx_gap = SUM_W'(head_idx_ff) - SUM_W'(ack_cnt);
   assign idx_wrap = idx_gap[SUM_W-1] ? (idx_gap + DEPTH_SUM) : idx_gap;
   assign head_next = (head_idx_ff == LAST_IDX) ? '0 : (head_idx_ff + IDX_W'(1));
   assign rs_idx_next = (rs_idx_ff == LAST_IDX) ? '0 : (rs_idx_ff + IDX_W'(1));

   assign status.room = (cnt_ff < window_ff) && (SUM_W'(cnt_ff) < DEPTH_SUM);
   assign status.ack_ok = ack_diff < SEQ_W'(cnt_ff);
   assign status.due = timer_ff >= timeout_ff;
   assign status.busy = cnt_ff != '0;
   assign status.resend_last = rs_cnt_ff == (cnt_ff - WIN_W'(1));

   assign ram_rd_en = cmd.tick_fire || cmd.resend_emit;
   assign ram_rd_addr = cmd.tick_fire ? base_idx_ff : rs_idx_next;

   gbn_ram #(
      .WIDTH(PAYLOAD_BITS),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.send_ok),
      .wr_addr(head_idx_ff),
      .wr_data(req_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      window_in = window_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW:  window_in = csr_wdata[WIN_W-1:0];
            REG_TIMEOUT: timeout_in = csr_wdata[TIMEOUT_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      base_in = base_ff;
      next_in = next_ff;
      cnt_in = cnt_ff;
      timer_in = timer_ff;
      head_idx_in = head_idx_ff;
      base_idx_in = base_idx_ff;
      rs_idx_in = rs_idx_ff;
      rs_cnt_in = rs_cnt_ff;
      rs_seq_in = rs_seq_ff;
      kind_in = kind_ff;
      seq_in = seq_ff;
      data_in = data_ff;
      last_in = last_ff;

      if (cmd.send_ok) begin
         next_in = next_ff + SEQ_W'(1);
         cnt_in = cnt_ff + WIN_W'(1);
         head_idx_in = head_next;
         if (cnt_ff == '0) begin
            timer_in = '0;
         end
         kind_in = KIND_SENT;
         seq_in = next_ff;
         data_in = req_data;
         last_in = 1'b1;
      end
      if (cmd.send_refuse) begin
         kind_in = KIND_REFUSED;
         seq_in = '0;
         data_in = req_data;
         last_in = 1'b1;
      end
      if (cmd.ack_take) begin
         base_in = ack_base;
         cnt_in = ack_cnt;
         base_idx_in = idx_wrap[IDX_W-1:0];
         if (ack_cnt != '0) begin
            timer_in = '0;
         end
         kind_in = KIND_ACKED;
         seq_in = ack_base;
         data_in = '0;
         last_in = 1'b1;
      end
      if (cmd.tick_count) begin
         timer_in = timer_ff + TIMEOUT_W'(1);
      end
      if (cmd.tick_fire) begin
         timer_in = '0;
         rs_idx_in = base_idx_ff;
         rs_cnt_in = '0;
         rs_seq_in = base_ff;
      end
      if (cmd.resend_emit) begin
         rs_idx_in = rs_idx_next;
         rs_cnt_in = rs_cnt_ff + WIN_W'(1);
         rs_seq_in = rs_seq_ff + SEQ_W'(1);
         kind_in = KIND_RESENT;
         seq_in = rs_seq_ff;
         data_in = ram_rd_data;
         last_in = status.resend_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= RESET_WINDOW;
         timeout_ff <= RESET_TIMEOUT;
         base_ff <= '0;
         next_ff <= '0;
         cnt_ff <= '0;
         timer_ff <= '0;
         head_idx_ff <= '0;
         base_idx_ff <= '0;
         rs_cnt_ff <= '0;
      end else begin
         window_ff <= window_in;
         timeout_ff <= timeout_in;
         base_ff <= base_in;
         next_ff <= next_in;
         cnt_ff <= cnt_in;
         timer_ff <= timer_in;
         head_idx_ff <= head_idx_in;
         base_idx_ff <= base_idx_in;
         rs_cnt_ff <= rs_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rs_idx_ff <= rs_idx_in;
      rs_seq_ff <= rs_seq_in;
      kind_ff <= kind_in;
      seq_ff <= seq_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_kind = kind_ff;
   assign rsp_seq_out = seq_ff;
   assign rsp_payload_out = data_ff;
   assign rsp_last = last_ff;

   // The outstanding count must never exceed what the store can hold.
   a_cnt_fits_store: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(cnt_ff) <= DEPTH_SUM)
      else $error("outstanding count exceeds store depth");

   // The outstanding count tracks the distance between the window edges.
   a_cnt_matches_seq: assert property (@(posedge clock) disable iff (reset)
      (next_ff - base_ff) == SEQ_W'(cnt_ff))
      else $error("outstanding count out of step with sequence numbers");

   // A send always leaves at least one packet outstanding.
   a_idx_gap: assert property (@(posedge clock) disable iff (reset)
      cmd.send_ok |=> (cnt_ff != '0))
      else $error("send left the window empty");

endmodule

`default_nettype wire

// File: hdl/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [MODE_W-1:0] req_mode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire status_type        status,
   output cmd_type                cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESEND = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic accept;
   logic emit;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_SEND: begin
                     cmd.send_ok = status.room;
                     cmd.send_refuse = !status.room;
                  end
                  MODE_ACK: begin
                     cmd.ack_take = status.ack_ok;
                  end
                  MODE_TICK: begin
                     cmd.tick_count = !status.due;
                     cmd.tick_fire = status.due;
                     if (status.due && status.busy) begin
                        state_in = ST_RESEND;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RESEND: begin
            if (slot_free) begin
               cmd.resend_emit = 1'b1;
               if (status.resend_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign emit = cmd.send_ok || cmd.send_refuse || cmd.ack_take || cmd.resend_emit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // No acknowledgement is taken during a resend, so the window cannot drain.
   a_resend_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESEND) |-> status.busy)
      else $error("resend running with an empty window");

   // A timeout with packets outstanding starts a resend.
   a_fire_resend: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick_fire && status.busy) |=> (state_ff == ST_RESEND))
      else $error("timeout did not start a resend");

   // A result is loaded only when the output register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// File: hdl/go_back_n_sender.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_mode, req_ack_seq, req_payload
// rsp       out        rsp_valid/rsp_ready  rsp_kind, rsp_seq_out, rsp_payload_out, rsp_last
// csr       in         csr_we               csr_index, csr_wdata
//
// Sends, acknowledgements and ticks follow back to back while the result register drains.
// A timeout that fires with packets outstanding then resends them in order, paced by the
// one read port of the packet store; no new item is taken until the last resend is out.
// Reset is synchronous and leaves the window empty with the default configuration.
// A stalled result holds the result register, and no new item is taken until it moves.

module go_back_n_sender import gbn_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [MODE_W-1:0]       req_mode,
   input  wire logic [SEQ_W-1:0]        req_ack_seq,
   input  wire logic [PAYLOAD_BITS-1:0] req_payload,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [KIND_W-1:0]       rsp_kind,
   output logic      [SEQ_W-1:0]        rsp_seq_out,
   output logic      [PAYLOAD_BITS-1:0] rsp_payload_out,
   output logic                         rsp_last
);

   cmd_type    cmd;
   status_type status;

   gbn_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_mode (req_mode),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   gbn_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_ack_seq    (req_ack_seq),
      .req_payload    (req_payload),
      .cmd            (cmd),
      .status         (status),
      .rsp_kind       (rsp_kind),
      .rsp_seq_out    (rsp_seq_out),
      .rsp_payload_out(rsp_payload_out),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import gbn_pkg::*;

   localparam int STORE_DEPTH = STORE_DEPTH_DEF;
   localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int QUIET_CYCLES = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 44;
   localparam int REPORT_LIMIT = 10;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [SEQ_W-1:0]        ack_seq;
      logic [PAYLOAD_BITS-1:0] payload;
   } arq_request_type;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [SEQ_W-1:0]        seq;
      logic [PAYLOAD_BITS-1:0] data;
      logic                    last;
   } arq_packet_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [MODE_W-1:0]       req_mode = '0;
   logic [SEQ_W-1:0]        req_ack_seq = '0;
   logic [PAYLOAD_BITS-1:0] req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [KIND_W-1:0]       rsp_kind;
   logic [SEQ_W-1:0]        rsp_seq_out;
   logic [PAYLOAD_BITS-1:0] rsp_payload_out;
   logic                    rsp_last;

   // Sender state as the block should hold it, advanced on every accepted transfer.
   logic [WIN_W-1:0]        m_window = RESET_WINDOW;
   logic [TIMEOUT_W-1:0]    m_timeout = RESET_TIMEOUT;
   logic [SEQ_W-1:0]        m_base = '0;
   logic [SEQ_W-1:0]        m_next = '0;
   logic [TIMEOUT_W-1:0]    m_timer = '0;
   logic [PAYLOAD_BITS-1:0] m_words [STORE_DEPTH];

   // Window edges as seen by the stimulus generator, which runs ahead of the block.
   logic [SEQ_W-1:0]        g_base = '0;
   logic [SEQ_W-1:0]        g_next = '0;

   arq_request_type         req_backlog [$];
   arq_packet_type          arq_emissions [$];
   arq_request_type         next_req;
   arq_packet_type          want_pkt;
   arq_packet_type          got_pkt;
   int                      items_queued = 0;
   int                      items_taken = 0;
   int                      error_count = 0;
   int                      cycle_count = 0;
   int                      sender_idle_pct = 0;
   int                      stall_pct = 0;
   int                      hold_left = 0;
   logic                    hold_served = 1'b0;
   logic                    pressure_on = 1'b0;

   go_back_n_sender dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_ack_seq     (req_ack_seq),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   function automatic logic [SEQ_W-1:0] window_limit(input logic [WIN_W-1:0] win);
      return (win > STORE_DEPTH) ? SEQ_W'(STORE_DEPTH) : SEQ_W'(win);
   endfunction

   function automatic arq_packet_type build_packet(input logic [KIND_W-1:0] kind,
                                                   input logic [SEQ_W-1:0] seq,
                                                   input logic [PAYLOAD_BITS-1:0] data,
                                                   input logic last);
      arq_packet_type pkt;
      pkt.kind = kind;
      pkt.seq = seq;
      pkt.data = data;
      pkt.last = last;
      return pkt;
   endfunction

   task automatic expect_packet(input arq_packet_type pkt);
      arq_emissions = {arq_emissions, pkt};
   endtask

   task automatic arq_sender_step(input arq_request_type item);
      logic [SEQ_W-1:0] outstanding;
      logic [SEQ_W-1:0] new_base;
      logic [SEQ_W-1:0] gap;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] i;
      outstanding = m_next - m_base;
      case (item.mode)
         MODE_SEND: begin
            if (outstanding < window_limit(m_window)) begin
               m_words[int'(m_next % STORE_DEPTH)] = item.payload;
               expect_packet(build_packet(KIND_SENT, m_next, item.payload, 1'b1));
               if (outstanding == 0) m_timer = '0;
               m_next = m_next + SEQ_W'(1);
            end else begin
               expect_packet(build_packet(KIND_REFUSED, '0, item.payload, 1'b1));
            end
         end
         MODE_ACK: begin
            new_base = item.ack_seq + SEQ_W'(1);
            gap = new_base - m_base;
            if (gap != 0 && gap <= outstanding) begin
               m_base = new_base;
               if (m_base != m_next) m_timer = '0;
               expect_packet(build_packet(KIND_ACKED, m_base, '0, 1'b1));
            end
         end
         MODE_TICK: begin
            if (m_timer < m_timeout) begin
               m_timer = m_timer + TIMEOUT_W'(1);
            end else begin
               m_timer = '0;
               for (i = 0; i < outstanding; i++) begin
                  seq = m_base + i;
                  expect_packet(build_packet(KIND_RESENT, seq,
                     m_words[int'(seq % STORE_DEPTH)], (i + SEQ_W'(1) == outstanding)));
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] ack,
                             input logic [PAYLOAD_BITS-1:0] data);
      arq_request_type item;
      logic [SEQ_W-1:0] outstanding;
      logic [SEQ_W-1:0] gap;
      item.mode = mode;
      item.ack_seq = ack;
      item.payload = data;
      outstanding = g_next - g_base;
      if (mode == MODE_SEND && outstanding < window_limit(m_window))
         g_next = g_next + SEQ_W'(1);
      if (mode == MODE_ACK) begin
         gap = ack + SEQ_W'(1) - g_base;
         if (gap != 0 && gap <= outstanding) g_base = ack + SEQ_W'(1);
      end
      req_backlog = {req_backlog, item};
      items_queued++;
   endtask

   task automatic queue_random_traffic(input int count);
      int pick;
      logic [SEQ_W-1:0] outstanding;
      logic [SEQ_W-1:0] ack;
      repeat (count) begin
         pick = $urandom_range(99);
         outstanding = g_next - g_base;
         if (pick < 42) begin
            queue_item(MODE_SEND, $urandom, $urandom);
         end else if (pick < 67) begin
            case ($urandom_range(5))
               0: ack = g_base - 1 - $urandom_range(3);
               1: ack = g_next + $urandom_range(4);
               2: ack = $urandom;
               default: ack = (outstanding != 0) ? g_base + $urandom_range(outstanding - 1)
                                                 : g_base - 1;
            endcase
            queue_item(MODE_ACK, ack, $urandom);
         end else if (pick < 95) begin
            queue_item(MODE_TICK, $urandom, $urandom);
         end else begin
            queue_item(MODE_UNUSED, $urandom, $urandom);
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == REG_WINDOW) m_window = value[WIN_W-1:0];
      else m_timeout = value[TIMEOUT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (items_taken != items_queued || arq_emissions.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            arq_sender_step(arq_request_type'({req_mode, req_ack_seq, req_payload}));
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_req = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_req.mode;
               req_ack_seq <= next_req.ack_seq;
               req_payload <= next_req.payload;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The long hold-off lets the result register back up until the input stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_served <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_on && !hold_served) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_pkt = build_packet(rsp_kind, rsp_seq_out, rsp_payload_out, rsp_last);
         if (arq_emissions.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected transfer: kind %0d seq %h data %h last %b",
                        got_pkt.kind, got_pkt.seq, got_pkt.data, got_pkt.last);
         end else begin
            want_pkt = arq_emissions.pop_front();
            if (got_pkt.kind !== want_pkt.kind || got_pkt.seq !== want_pkt.seq ||
                got_pkt.data !== want_pkt.data || got_pkt.last !== want_pkt.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("mismatch: kind %0d/%0d seq %h/%h data %h/%h last %b/%b (exp/act)",
                           want_pkt.kind, got_pkt.kind, want_pkt.seq, got_pkt.seq,
                           want_pkt.data, got_pkt.data, want_pkt.last, got_pkt.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int phase;
      logic [WIN_W-1:0] win;
      logic [TIMEOUT_W-1:0] tmo;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Fill the window at the default settings, then stale, future and wrapped acks.
      queue_item(MODE_SEND, $urandom, 32'h0000_0000);
      queue_item(MODE_SEND, $urandom, 32'hFFFF_FFFF);
      queue_item(MODE_SEND, $urandom, 32'h5555_5555);
      queue_item(MODE_SEND, $urandom, 32'hAAAA_AAAA);
      queue_item(MODE_SEND, $urandom, $urandom);
      queue_item(MODE_ACK, 32'hFFFF_FFFF, $urandom);
      queue_item(MODE_ACK, 32'd9, $urandom);
      queue_item(MODE_ACK, 32'd0, $urandom);
      queue_item(MODE_ACK, 32'd0, $urandom);
      queue_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(MODE_TICK, $urandom, $urandom);
      wait_idle();

      // A zero timeout fires on every tick, also with nothing outstanding.
      write_csr(REG_TIMEOUT, '0);
      write_csr(REG_WINDOW, CSR_DATA_W'(63));
      queue_item(MODE_TICK, $urandom, $urandom);
      queue_item(MODE_ACK, 32'd3, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom);
      queue_item(MODE_SEND, $urandom, $urandom);
      queue_item(MODE_SEND, $urandom, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom);
      wait_idle();

      // With a zero window every send is refused, while retransmission still runs.
      write_csr(REG_WINDOW, '0);
      write_csr(REG_TIMEOUT, CSR_DATA_W'(1));
      queue_item(MODE_SEND, $urandom, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom);
      queue_item(MODE_ACK, 32'd5, $urandom);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin win = 6'd1; tmo = '0; end
            1: begin win = 6'd63; tmo = 16'd3; end
            2: begin
               win = WIN_W'($urandom_range(16, 2));
               tmo = TIMEOUT_W'($urandom_range(10, 1));
            end
            3: begin win = 6'd8; tmo = 16'hFFFF; end
            4: begin win = 6'd63; tmo = 16'd2; end
            5: begin
               win = WIN_W'($urandom_range(63, 1));
               tmo = TIMEOUT_W'($urandom_range(6, 0));
            end
            6: begin win = '0; tmo = 16'd1; end
            default: begin
               win = WIN_W'($urandom_range(63, 1));
               tmo = TIMEOUT_W'($urandom_range(20, 0));
            end
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0; stall_pct = 0; end
            1: begin sender_idle_pct = 71; stall_pct = 0; end
            2: begin sender_idle_pct = 0; stall_pct = 71; end
            default: begin sender_idle_pct = 11; stall_pct = 11; end
         endcase
         write_csr(REG_WINDOW, CSR_DATA_W'(win));
         write_csr(REG_TIMEOUT, tmo);
         queue_random_traffic(PHASE_ITEMS);
         if (phase == 4) pressure_on <= 1'b1;
         wait_idle();
      end

      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
hdl/gbn_pkg.sv
hdl/gbn_ram.sv
hdl/gbn_datapath.sv
hdl/gbn_ctrl.sv
hdl/go_back_n_sender.sv
dv/tb.sv
